FILE: rtl/page_table_walker_top_assert.svh
// Assertion macros shared by the queue and back-end modules of the page table walker.
`ifndef PAGE_TABLE_WALKER_TOP_ASSERT_SVH
`define PAGE_TABLE_WALKER_TOP_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define PTW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptw assertion failed");

// Check a consequence in the cycle after its antecedent.
`define PTW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptw assertion failed");

`endif

FILE: rtl/ptw_pkg.sv
// Types, codes and decode helpers for the page table walker.
package ptw_pkg;

  localparam int ADDR_W = 52;
  localparam int VA_W   = 48;

  localparam logic [63:0] LOW32        = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] LM_ROOT_MASK = 64'h000f_ffff_ffff_f000;
  localparam logic [63:0] PAE_ROOT_MASK = 64'h0000_0000_ffff_ffe0;
  localparam logic [63:0] LEG_ROOT_MASK = 64'h0000_0000_ffff_f000;
  localparam logic [ADDR_W:0] TABLE_SPAN = 53'd4096;

  typedef enum logic {
    OP_START = 1'b0,
    OP_ENTRY = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    LVL_PML4E    = 3'd0,
    LVL_PDPE     = 3'd1,
    LVL_PAE_PDPE = 3'd2,
    LVL_PDE64    = 3'd3,
    LVL_PTE64    = 3'd4,
    LVL_PDE32    = 3'd5,
    LVL_PTE32    = 3'd6
  } level_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_PROTECTED   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    SZ_4K = 2'd0,
    SZ_2M = 2'd1,
    SZ_4M = 2'd2,
    SZ_1G = 2'd3
  } page_size_t;

  typedef enum logic {
    RK_READ_REQ = 1'b0,
    RK_DONE     = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    CFG_LONG_MODE  = 3'd0,
    CFG_PAE_ENABLE = 3'd1,
    CFG_PSE_ENABLE = 3'd2,
    CFG_GB_PAGES   = 3'd3,
    CFG_PROT_BASE  = 3'd4,
    CFG_PROT_END   = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic              long_mode;
    logic              pae_enable;
    logic              pse_enable;
    logic              gb_pages_enable;
    logic [ADDR_W-1:0] protected_base;
    logic [ADDR_W-1:0] protected_end;
  } cfg_t;

  // Classified item: a start carries the masked root table base in data.
  typedef struct packed {
    logic            is_entry;
    level_t          level;
    logic [VA_W-1:0] vaddr;
    logic [63:0]     data;
  } cmd_t;

  typedef struct packed {
    result_kind_t      kind;
    logic [ADDR_W-1:0] read_address;
    status_t           status;
    level_t            level;
    page_size_t        page_size;
    logic [ADDR_W-1:0] phys_address;
    logic [ADDR_W-1:0] entry_address;
  } res_t;

  // Byte offset of the entry inside its table for a given level.
  function automatic logic [11:0] entry_offset(level_t lvl, logic [VA_W-1:0] va);
    logic [11:0] off;
    unique case (lvl)
      LVL_PML4E:    off = {va[47:39], 3'b000};
      LVL_PDPE:     off = {va[38:30], 3'b000};
      LVL_PAE_PDPE: off = {7'b0, va[31:30], 3'b000};
      LVL_PDE64:    off = {va[29:21], 3'b000};
      LVL_PTE64:    off = {va[20:12], 3'b000};
      LVL_PDE32:    off = {va[31:22], 2'b00};
      LVL_PTE32:    off = {va[21:12], 2'b00};
      default:      off = 12'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: rtl/ptw_fifo.sv
// Small synchronous queue of packed items; the user must keep depth a power of two, which the module does not check.
module ptw_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  `include "page_table_walker_top_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push_ok, pop_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wptr_nxt = push_ok ? wptr_r + AW'(1) : wptr_r;
    rptr_nxt = pop_ok ? rptr_r + AW'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  `PTW_ASSERT_NOW(a_fifo_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH))
  `PTW_ASSERT_NXT(a_fifo_full_holds, full && !pop, full)

endmodule

FILE: rtl/ptw_front.sv
// Front end: takes input items and classifies them into walk commands.
module ptw_front (
  input  logic                       in_push,
  input  logic                       in_opcode,
  input  logic [63:0]                in_root_pointer,
  input  logic [63:0]                in_virtual_address,
  input  logic [63:0]                in_entry_value,
  input  ptw_pkg::cfg_t              cfg,
  input  logic                       q_full,
  output logic                       q_push,
  output ptw_pkg::cmd_t              cmd
);

  assign q_push = in_push && !q_full;

  // Pick the root table format and first level for a start
  always_comb begin
    cmd.is_entry = (ptw_pkg::opcode_t'(in_opcode) == ptw_pkg::OP_ENTRY);
    cmd.vaddr    = in_virtual_address[ptw_pkg::VA_W-1:0];
    cmd.level    = ptw_pkg::LVL_PML4E;
    cmd.data     = in_entry_value;
    if (!cmd.is_entry) begin
      if (cfg.long_mode) begin
        cmd.level = ptw_pkg::LVL_PML4E;
        cmd.data  = in_root_pointer & ptw_pkg::LM_ROOT_MASK;
      end else if (cfg.pae_enable) begin
        cmd.level = ptw_pkg::LVL_PAE_PDPE;
        cmd.data  = in_root_pointer & ptw_pkg::PAE_ROOT_MASK;
      end else begin
        cmd.level = ptw_pkg::LVL_PDE32;
        cmd.data  = in_root_pointer & ptw_pkg::LEG_ROOT_MASK;
      end
    end
  end

endmodule

FILE: rtl/ptw_back.sv
// Back end: holds the walk state and turns each command into a result.
module ptw_back #(
  parameter int PHYS_BITS = 52
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ptw_pkg::cfg_t cfg,
  input  ptw_pkg::cmd_t cmd,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          res_full,
  output logic          res_push,
  output ptw_pkg::res_t res
);

  `include "page_table_walker_top_assert.svh"

  localparam int AW = ptw_pkg::ADDR_W;
  localparam logic [AW-1:0] PMASK = AW'((65'd1 << PHYS_BITS) - 65'd1);

  logic                      busy_r, busy_nxt;
  ptw_pkg::level_t           level_r, level_nxt;
  logic [ptw_pkg::VA_W-1:0]  vaddr_r, vaddr_nxt;
  logic [AW-1:0]             pend_r, pend_nxt;

  logic                      consume;
  logic                      has_res;
  logic [ptw_pkg::VA_W-1:0]  va;
  logic [63:0]               e;
  logic [AW-1:0]             nxt;
  logic                      do_enter, do_finish, do_np;
  logic [AW-1:0]             ent_base, ent_base_m, ent_addr;
  ptw_pkg::level_t           ent_lvl, fin_lvl;
  ptw_pkg::page_size_t       fin_size;
  logic [AW-1:0]             fin_phys;
  logic                      prot_hit;

  assign consume  = !q_empty && !res_full;
  assign q_pop    = consume;
  assign res_push = consume && has_res;

  // Decode the command against the pending level
  always_comb begin
    va = cmd.is_entry ? vaddr_r : cmd.vaddr;
    e  = cmd.data;
    if (level_r == ptw_pkg::LVL_PDE32 || level_r == ptw_pkg::LVL_PTE32) begin
      e = cmd.data & ptw_pkg::LOW32;
    end
    nxt       = {e[51:12], 12'b0};
    do_enter  = 1'b0;
    do_finish = 1'b0;
    do_np     = 1'b0;
    ent_base  = nxt;
    ent_lvl   = ptw_pkg::LVL_PML4E;
    fin_lvl   = level_r;
    fin_size  = ptw_pkg::SZ_4K;
    fin_phys  = {e[51:12], va[11:0]};
    if (!cmd.is_entry) begin
      do_enter = 1'b1;
      ent_base = cmd.data[AW-1:0];
      ent_lvl  = cmd.level;
    end else if (busy_r && level_r <= ptw_pkg::LVL_PTE32) begin
      if (!e[0]) begin
        do_np = 1'b1;
      end else begin
        unique case (level_r)
          ptw_pkg::LVL_PML4E: begin
            do_enter = 1'b1;
            ent_lvl  = ptw_pkg::LVL_PDPE;
          end
          ptw_pkg::LVL_PDPE: begin
            if (cfg.gb_pages_enable && e[7]) begin
              do_finish = 1'b1;
              fin_size  = ptw_pkg::SZ_1G;
              fin_phys  = {e[51:30], va[29:0]};
            end else begin
              do_enter = 1'b1;
              ent_lvl  = ptw_pkg::LVL_PDE64;
            end
          end
          ptw_pkg::LVL_PAE_PDPE: begin
            do_enter = 1'b1;
            ent_lvl  = ptw_pkg::LVL_PDE64;
          end
          ptw_pkg::LVL_PDE64: begin
            if ((cfg.long_mode || cfg.pse_enable) && e[7]) begin
              do_finish = 1'b1;
              fin_size  = ptw_pkg::SZ_2M;
              fin_phys  = {e[51:21], va[20:0]};
            end else begin
              do_enter = 1'b1;
              ent_lvl  = ptw_pkg::LVL_PTE64;
            end
          end
          ptw_pkg::LVL_PDE32: begin
            if (cfg.pse_enable && e[7]) begin
              do_finish = 1'b1;
              fin_size  = ptw_pkg::SZ_4M;
              fin_phys  = {20'b0, e[31:22], va[21:0]};
            end else begin
              do_enter = 1'b1;
              ent_lvl  = ptw_pkg::LVL_PTE32;
            end
          end
          default: begin
            // Last level of either format maps a 4K page
            do_finish = 1'b1;
          end
        endcase
      end
    end
  end

  // Form the entry address and check the table against the protected area
  always_comb begin
    ent_base_m = ent_base & PMASK;
    ent_addr   = (ent_base_m | {{(AW-12){1'b0}}, ptw_pkg::entry_offset(ent_lvl, va)}) & PMASK;
    prot_hit   = (cfg.protected_end > cfg.protected_base)
              && (ent_base_m < cfg.protected_end)
              && (({1'b0, ent_base_m} + ptw_pkg::TABLE_SPAN) > {1'b0, cfg.protected_base});
  end

  // Build the result and the next walk state
  always_comb begin
    res       = '0;
    has_res   = 1'b0;
    busy_nxt  = busy_r;
    level_nxt = level_r;
    vaddr_nxt = vaddr_r;
    pend_nxt  = pend_r;
    if (!cmd.is_entry) begin
      vaddr_nxt = cmd.vaddr;
    end
    if (cmd.is_entry) begin
      // Any entry clears busy; an unprotected step into the next table sets it again
      busy_nxt = 1'b0;
    end
    if (do_enter) begin
      has_res = 1'b1;
      if (prot_hit) begin
        busy_nxt          = 1'b0;
        res.kind          = ptw_pkg::RK_DONE;
        res.status        = ptw_pkg::ST_PROTECTED;
        res.level         = ent_lvl;
        res.entry_address = ent_addr;
      end else begin
        busy_nxt         = 1'b1;
        level_nxt        = ent_lvl;
        pend_nxt         = ent_addr;
        res.kind         = ptw_pkg::RK_READ_REQ;
        res.read_address = ent_addr;
        res.level        = ent_lvl;
      end
    end else if (do_np) begin
      has_res           = 1'b1;
      res.kind          = ptw_pkg::RK_DONE;
      res.status        = ptw_pkg::ST_NOT_PRESENT;
      res.level         = level_r;
      res.entry_address = pend_r;
    end else if (do_finish) begin
      has_res           = 1'b1;
      res.kind          = ptw_pkg::RK_DONE;
      res.status        = ptw_pkg::ST_OK;
      res.level         = fin_lvl;
      res.page_size     = fin_size;
      res.phys_address  = fin_phys & PMASK;
      res.entry_address = pend_r;
    end
  end

  // Hold walk state; update it only when a command is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      level_r <= ptw_pkg::LVL_PML4E;
      vaddr_r <= '0;
      pend_r  <= '0;
    end else if (consume) begin
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
      vaddr_r <= vaddr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  `PTW_ASSERT_NXT(a_done_ends_walk, res_push && res.kind == ptw_pkg::RK_DONE, !busy_r)
  `PTW_ASSERT_NXT(a_req_tracks_level,
                  res_push && res.kind == ptw_pkg::RK_READ_REQ,
                  busy_r && pend_r == $past(res.read_address))
  `PTW_ASSERT_NOW(a_push_needs_room, res_push, consume && !res_full)

endmodule

FILE: rtl/page_table_walker_top.sv
// Top level of the page table walker: config registers, queues, front and back ends.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  input    | push / full        | in_opcode, in_root_pointer, in_virtual_address,
//           |                    | in_entry_value
//  result   | empty / pop        | out_result_kind, out_read_address, out_status,
//           |                    | out_level_code, out_page_size_code,
//           |                    | out_phys_address, out_entry_address
//  config   | cfg_we             | cfg_index, cfg_wdata
//
// One item per cycle sustained while the result queue has room; each item is resolved combinationally in the back end.
// An item passes through the command queue and the back end into the result queue, whose head drives the result ports.
// The command queue and the result queue each hold QUEUE_DEPTH items.
// full rises when the command queue is full; the back end halts while the result
// queue is full. Reset (synchronous) clears queues, walk state and registers.
module page_table_walker_top #(
  parameter int PHYS_BITS   = 52,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_opcode,
  input  logic [63:0] in_root_pointer,
  input  logic [63:0] in_virtual_address,
  input  logic [63:0] in_entry_value,
  output logic        empty,
  input  logic        pop,
  output logic        out_result_kind,
  output logic [51:0] out_read_address,
  output logic [1:0]  out_status,
  output logic [2:0]  out_level_code,
  output logic [1:0]  out_page_size_code,
  output logic [51:0] out_phys_address,
  output logic [51:0] out_entry_address,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [51:0] cfg_wdata
);

  localparam int CMD_W = $bits(ptw_pkg::cmd_t);
  localparam int RES_W = $bits(ptw_pkg::res_t);

  ptw_pkg::cfg_t cfg_r;
  ptw_pkg::cmd_t front_cmd, head_cmd;
  ptw_pkg::res_t back_res, out_res;
  logic          q_push, q_full, q_pop, q_empty;
  logic          res_push, res_full;
  logic [CMD_W-1:0] head_bits;
  logic [RES_W-1:0] out_bits;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (ptw_pkg::cfg_idx_t'(cfg_index))
        ptw_pkg::CFG_LONG_MODE:  cfg_r.long_mode       <= cfg_wdata[0];
        ptw_pkg::CFG_PAE_ENABLE: cfg_r.pae_enable      <= cfg_wdata[0];
        ptw_pkg::CFG_PSE_ENABLE: cfg_r.pse_enable      <= cfg_wdata[0];
        ptw_pkg::CFG_GB_PAGES:   cfg_r.gb_pages_enable <= cfg_wdata[0];
        ptw_pkg::CFG_PROT_BASE:  cfg_r.protected_base  <= cfg_wdata;
        ptw_pkg::CFG_PROT_END:   cfg_r.protected_end   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign full = q_full;

  ptw_front u_front (
    .in_push            (push),
    .in_opcode          (in_opcode),
    .in_root_pointer    (in_root_pointer),
    .in_virtual_address (in_virtual_address),
    .in_entry_value     (in_entry_value),
    .cfg                (cfg_r),
    .q_full             (q_full),
    .q_push             (q_push),
    .cmd                (front_cmd)
  );

  ptw_fifo #(.W(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (front_cmd),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_bits),
    .empty (q_empty)
  );

  assign head_cmd = ptw_pkg::cmd_t'(head_bits);

  ptw_back #(.PHYS_BITS(PHYS_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .cmd      (head_cmd),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (back_res)
  );

  ptw_fifo #(.W(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_bits),
    .empty (empty)
  );

  // Unpack the oldest result onto the ports
  assign out_res            = ptw_pkg::res_t'(out_bits);
  assign out_result_kind    = out_res.kind;
  assign out_read_address   = out_res.read_address;
  assign out_status         = out_res.status;
  assign out_level_code     = out_res.level;
  assign out_page_size_code = out_res.page_size;
  assign out_phys_address   = out_res.phys_address;
  assign out_entry_address  = out_res.entry_address;

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for the page table walker: directed and random walks checked by a built-in predictor.
module tb;
  import ptw_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    result_kind_t kind;
    logic [51:0]  read_addr;
    status_t      status;
    level_t       level;
    page_size_t   size;
    logic [51:0]  phys;
    logic [51:0]  entry_addr;
  } walk_result_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_opcode;
  logic [63:0] in_root_pointer;
  logic [63:0] in_virtual_address;
  logic [63:0] in_entry_value;
  logic        empty;
  logic        pop = 1'b0;
  logic        out_result_kind;
  logic [51:0] out_read_address;
  logic [1:0]  out_status;
  logic [2:0]  out_level_code;
  logic [1:0]  out_page_size_code;
  logic [51:0] out_phys_address;
  logic [51:0] out_entry_address;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [51:0] cfg_wdata;

  // Predictor copy of the mode and protected area registers
  logic        mode_long = 1'b0;
  logic        mode_pae = 1'b0;
  logic        mode_pse = 1'b0;
  logic        mode_gb = 1'b0;
  logic [51:0] prot_lo = '0;
  logic [51:0] prot_hi = '0;

  // Predictor copy of the walk state
  logic        walk_active = 1'b0;
  level_t      walk_lvl = LVL_PML4E;
  logic [47:0] walk_va = '0;
  logic [51:0] walk_entry_addr = '0;

  walk_result_t pending_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycle_count = 0;

  page_table_walker_top u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (full),
    .in_opcode          (in_opcode),
    .in_root_pointer    (in_root_pointer),
    .in_virtual_address (in_virtual_address),
    .in_entry_value     (in_entry_value),
    .empty              (empty),
    .pop                (pop),
    .out_result_kind    (out_result_kind),
    .out_read_address   (out_read_address),
    .out_status         (out_status),
    .out_level_code     (out_level_code),
    .out_page_size_code (out_page_size_code),
    .out_phys_address   (out_phys_address),
    .out_entry_address  (out_entry_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Drive pop: long hold-offs first, random stalls otherwise
  always @(negedge clk) begin
    if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Check every popped result item against the oldest expectation
  always @(posedge clk) begin
    walk_result_t want;
    if (rst_n && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item: expected none, actual kind %0h level %0h",
                 $time, out_result_kind, out_level_code);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_kind", 64'(want.kind), 64'(out_result_kind));
        compare_field("read_address", 64'(want.read_addr), 64'(out_read_address));
        compare_field("status", 64'(want.status), 64'(out_status));
        compare_field("level_code", 64'(want.level), 64'(out_level_code));
        compare_field("page_size_code", 64'(want.size), 64'(out_page_size_code));
        compare_field("phys_address", 64'(want.phys), 64'(out_phys_address));
        compare_field("entry_address", 64'(want.entry_addr), 64'(out_entry_address));
      end
    end
  end

  function automatic void post_result(result_kind_t kind, logic [51:0] raddr, status_t st,
                                      level_t lvl, page_size_t sz, logic [51:0] phys,
                                      logic [51:0] ent);
    walk_result_t r;
    r.kind = kind;
    r.read_addr = raddr;
    r.status = st;
    r.level = lvl;
    r.size = sz;
    r.phys = phys;
    r.entry_addr = ent;
    pending_results.push_back(r);
  endfunction

  function automatic logic table_protected(logic [51:0] base);
    if (prot_hi <= prot_lo) return 1'b0;
    return (base < prot_hi) && (({1'b0, base} + 53'd4096) > {1'b0, prot_lo});
  endfunction

  // Step into a table: fail on the protected area, else request the entry
  function automatic void enter_table(logic [51:0] base, level_t lvl, logic [11:0] offset);
    logic [51:0] ea;
    ea = base + 52'(offset);
    if (table_protected(base)) begin
      walk_active = 1'b0;
      post_result(RK_DONE, '0, ST_PROTECTED, lvl, SZ_4K, '0, ea);
    end else begin
      walk_active = 1'b1;
      walk_lvl = lvl;
      walk_entry_addr = ea;
      post_result(RK_READ_REQ, ea, ST_OK, lvl, SZ_4K, '0, '0);
    end
  endfunction

  function automatic void finish_walk(level_t lvl, page_size_t sz, logic [51:0] phys);
    walk_active = 1'b0;
    post_result(RK_DONE, '0, ST_OK, lvl, sz, phys, walk_entry_addr);
  endfunction

  // Advance the predicted walk by one accepted item
  function automatic void walk_predict(opcode_t op, logic [63:0] root, logic [63:0] va,
                                       logic [63:0] ent);
    logic [63:0] e;
    logic [51:0] nxt;
    if (op == OP_START) begin
      walk_va = va[47:0];
      if (mode_long)
        enter_table({root[51:12], 12'b0}, LVL_PML4E, {va[47:39], 3'b000});
      else if (mode_pae)
        enter_table({20'b0, root[31:5], 5'b0}, LVL_PAE_PDPE, {7'b0, va[31:30], 3'b000});
      else
        enter_table({20'b0, root[31:12], 12'b0}, LVL_PDE32, {va[31:22], 2'b00});
      return;
    end
    if (!walk_active) return;
    e = ent;
    if (walk_lvl == LVL_PDE32 || walk_lvl == LVL_PTE32) e[63:32] = '0;
    if (!e[0]) begin
      walk_active = 1'b0;
      post_result(RK_DONE, '0, ST_NOT_PRESENT, walk_lvl, SZ_4K, '0, walk_entry_addr);
      return;
    end
    nxt = {e[51:12], 12'b0};
    case (walk_lvl)
      LVL_PML4E: enter_table(nxt, LVL_PDPE, {walk_va[38:30], 3'b000});
      LVL_PDPE: begin
        if (mode_gb && e[7])
          finish_walk(LVL_PDPE, SZ_1G, {e[51:30], walk_va[29:0]});
        else
          enter_table(nxt, LVL_PDE64, {walk_va[29:21], 3'b000});
      end
      LVL_PAE_PDPE: enter_table(nxt, LVL_PDE64, {walk_va[29:21], 3'b000});
      LVL_PDE64: begin
        if ((mode_long || mode_pse) && e[7])
          finish_walk(LVL_PDE64, SZ_2M, {e[51:21], walk_va[20:0]});
        else
          enter_table(nxt, LVL_PTE64, {walk_va[20:12], 3'b000});
      end
      LVL_PTE64: finish_walk(LVL_PTE64, SZ_4K, {e[51:12], walk_va[11:0]});
      LVL_PDE32: begin
        if (mode_pse && e[7])
          finish_walk(LVL_PDE32, SZ_4M, {20'b0, e[31:22], walk_va[21:0]});
        else
          enter_table({20'b0, e[31:12], 12'b0}, LVL_PTE32, {walk_va[21:12], 2'b00});
      end
      default: finish_walk(LVL_PTE32, SZ_4K, {20'b0, e[31:12], walk_va[11:0]});
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Address close to either edge of the protected area
  function automatic logic [51:0] near_protected();
    logic [51:0] anchor;
    anchor = $urandom_range(1) ? prot_lo : prot_hi - 52'd1;
    return anchor + 52'($urandom_range(8192)) - 52'd4096;
  endfunction

  function automatic logic [63:0] table_entry();
    logic [63:0] e;
    logic [51:0] near;
    e = rand64();
    e[0] = ($urandom_range(99) < 90);
    if ($urandom_range(3) == 0) begin
      near = near_protected();
      e[51:12] = near[51:12];
    end
    return e;
  endfunction

  function automatic logic [63:0] root_value();
    logic [63:0] r;
    r = rand64();
    if ($urandom_range(3) == 0) r[51:0] = near_protected();
    return r;
  endfunction

  // Offer one item, hold it until taken, then predict its result
  task automatic send_item(opcode_t op, logic [63:0] root, logic [63:0] va,
                           logic [63:0] ent);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_opcode <= op;
    in_root_pointer <= root;
    in_virtual_address <= va;
    in_entry_value <= ent;
    do @(posedge clk); while (full);
    walk_predict(op, root, va, ent);
  endtask

  task automatic send_start(logic [63:0] root, logic [63:0] va);
    send_item(OP_START, root, va, rand64());
  endtask

  task automatic send_entry(logic [63:0] ent);
    send_item(OP_ENTRY, rand64(), rand64(), ent);
  endtask

  // Drop push and wait until every expected result item is out
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [51:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LONG_MODE:  mode_long = value[0];
      CFG_PAE_ENABLE: mode_pae = value[0];
      CFG_PSE_ENABLE: mode_pse = value[0];
      CFG_GB_PAGES:   mode_gb = value[0];
      CFG_PROT_BASE:  prot_lo = value;
      CFG_PROT_END:   prot_hi = value;
      default: ;
    endcase
  endtask

  task automatic set_mode(bit lm, bit pae, bit pse, bit gb);
    write_reg(CFG_LONG_MODE, 52'(lm));
    write_reg(CFG_PAE_ENABLE, 52'(pae));
    write_reg(CFG_PSE_ENABLE, 52'(pse));
    write_reg(CFG_GB_PAGES, 52'(gb));
  endtask

  task automatic set_protected(logic [51:0] base, logic [51:0] lim);
    write_reg(CFG_PROT_BASE, base);
    write_reg(CFG_PROT_END, lim);
  endtask

  // Pick one random item: mostly well-formed walks, some restarts and strays
  task automatic random_item(output bit counted);
    int r;
    r = $urandom_range(99);
    counted = 1'b1;
    if (walk_active && r < 94) begin
      send_entry(table_entry());
    end else if (!walk_active && r < 8) begin
      counted = 1'b0;
      send_entry(rand64());
    end else begin
      send_start(root_value(), rand64());
    end
  endtask

  task automatic pick_config();
    logic [51:0] base;
    logic [51:0] lim;
    set_mode(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
             1'($urandom_range(1)));
    case ($urandom_range(3))
      0: begin
        base = {20'b0, $urandom};
        lim = base + 52'($urandom_range(12288, 1));
      end
      1: begin
        base = 52'(rand64());
        lim = base + 52'($urandom_range(1 << 20, 1));
      end
      2: begin
        base = 52'(rand64());
        lim = base;
      end
      default: begin
        base = {20'b0, $urandom};
        lim = base - 52'($urandom_range(4096));
      end
    endcase
    set_protected(base, lim);
  endtask

  // Legacy two-level walks under reset settings, masking of the upper entry half
  task automatic test_legacy_walks();
    send_start('1, '1);
    send_entry('1);
    send_entry('1);
    send_start('0, '0);
    send_entry(64'hffff_ffff_0000_0000);
  endtask

  task automatic test_legacy_pse();
    settle();
    set_mode(1'b0, 1'b0, 1'b1, 1'b0);
    send_start(rand64(), rand64());
    send_entry(64'h0000_0000_ffc0_0081);
  endtask

  // PAE walks: directory large page ignored without PSE, taken with it
  task automatic test_pae_walks();
    settle();
    set_mode(1'b0, 1'b1, 1'b0, 1'b0);
    send_start('1, '1);
    send_entry('1);
    send_entry('1);
    settle();
    set_mode(1'b0, 1'b1, 1'b1, 1'b0);
    send_start(rand64(), rand64());
    send_entry(64'h1);
    send_entry(64'h81);
  endtask

  // Long mode: restart while busy, 2M pages, 1G only with gb pages on
  task automatic test_long_walks();
    settle();
    set_mode(1'b1, 1'b0, 1'b0, 1'b0);
    send_start('1, '1);
    send_entry('1);
    send_start('0, '1);
    send_entry('1);
    send_entry('1);
    send_entry('1);
    settle();
    set_mode(1'b1, 1'b1, 1'b1, 1'b1);
    send_start('0, '0);
    send_entry(64'h1);
    send_entry(64'h81);
  endtask

  // Whole space protected, empty area, and a table just below the area
  task automatic test_protected_tables();
    settle();
    set_protected('0, '1);
    send_start(rand64(), rand64());
    send_entry('1);
    settle();
    set_protected('1, '0);
    send_start('1, '1);
    settle();
    set_mode(1'b0, 1'b0, 1'b0, 1'b0);
    set_protected(52'h1000_0000, 52'h1000_0001);
    send_start(64'h0fff_f000, '0);
    send_entry(64'h1000_0001);
  endtask

  // Drop long mode while a directory entry is pending
  task automatic test_mid_walk_config();
    settle();
    set_protected('0, '0);
    set_mode(1'b1, 1'b0, 1'b0, 1'b0);
    send_start(rand64(), rand64());
    send_entry(64'h1);
    send_entry(64'h1);
    settle();
    set_mode(1'b0, 1'b0, 1'b0, 1'b0);
    send_entry(64'h81);
  endtask

  task automatic test_random_traffic();
    int phase;
    int k;
    int cnt;
    bit counted;
    for (phase = 0; phase < 4; phase++) begin
      for (k = 0; k < 4; k++) begin
        settle();
        pick_config();
        case (phase)
          0: begin send_idle_pct = 0;  stall_pct = 0;  end
          1: begin send_idle_pct = 61; stall_pct = 0;  end
          2: begin send_idle_pct = 0;  stall_pct = 61; end
          default: begin send_idle_pct = 28; stall_pct = 28; end
        endcase
        cnt = 0;
        while (cnt < 100) begin
          random_item(counted);
          if (counted) cnt++;
        end
      end
    end
  endtask

  // Hold off the receiver while items keep coming, so full rises
  task automatic test_full_backpressure();
    int cnt;
    bit counted;
    settle();
    send_idle_pct = 0;
    stall_pct = 0;
    @(posedge clk) hold_left = 300;
    cnt = 0;
    while (cnt < 60) begin
      random_item(counted);
      if (counted) cnt++;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    in_opcode = 1'b0;
    in_root_pointer = '0;
    in_virtual_address = '0;
    in_entry_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_legacy_walks();
    test_legacy_pse();
    test_pae_walks();
    test_long_walks();
    test_protected_tables();
    test_mid_walk_config();
    test_random_traffic();
    test_full_backpressure();
    settle();

    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
